>>> src/lrps_pkg.sv
// ----------------------------------------------------------------------------
// Laser range pose solver package
// Shared constants, the CORDIC angle table and the register indexes.
// ----------------------------------------------------------------------------
package lrps_pkg;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_MOUNT_SIDE  = 3'd0;
   localparam logic [2:0] REG_FRONT_OFS   = 3'd1;
   localparam logic [2:0] REG_SIDE_A_OFS  = 3'd2;
   localparam logic [2:0] REG_SIDE_B_OFS  = 3'd3;
   localparam logic [2:0] REG_BASELINE    = 3'd4;

   localparam int MAX_STEPS = 24;
   localparam int CW = 40;                       // CORDIC datapath width
   localparam logic signed [CW-1:0] INV_GAIN_Q30 = 40'sd652032875;
   localparam logic [18:0] FULL_TURN = 19'd368640;
   localparam logic signed [21:0] S22_MIN = -22'sd2097152;
   localparam logic signed [21:0] S22_MAX = 22'sd2097151;

   // Phase codes of the shared unit.
   localparam logic [1:0] PH_VEC = 2'd0;
   localparam logic [1:0] PH_ROT = 2'd1;

   // Angle of one CORDIC step, 1/262144 degree.
   function automatic logic signed [CW-1:0] atan_deg(input logic [4:0] idx);
      logic signed [CW-1:0] v;
      case (idx)
         5'd0: v = 40'sd11796480;  5'd1: v = 40'sd6963869;
         5'd2: v = 40'sd3679517;   5'd3: v = 40'sd1867780;
         5'd4: v = 40'sd937515;    5'd5: v = 40'sd469214;
         5'd6: v = 40'sd234664;    5'd7: v = 40'sd117339;
         5'd8: v = 40'sd58671;     5'd9: v = 40'sd29335;
         5'd10: v = 40'sd14668;    5'd11: v = 40'sd7334;
         5'd12: v = 40'sd3667;     5'd13: v = 40'sd1833;
         5'd14: v = 40'sd917;      5'd15: v = 40'sd458;
         5'd16: v = 40'sd229;      5'd17: v = 40'sd115;
         5'd18: v = 40'sd57;       5'd19: v = 40'sd29;
         5'd20: v = 40'sd14;       5'd21: v = 40'sd7;
         5'd22: v = 40'sd4;        5'd23: v = 40'sd2;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Saturate a wide signed value to 22 bits.
   function automatic logic signed [21:0] sat22(input logic signed [63:0] v);
      logic signed [21:0] r;
      if (v < 64'(S22_MIN)) r = S22_MIN;
      else if (v > 64'(S22_MAX)) r = S22_MAX;
      else r = v[21:0];
      return r;
   endfunction

endpackage

>>> src/lrps_cordic.sv
// ----------------------------------------------------------------------------
// Shared CORDIC step unit
// One micro-rotation per cycle, used first in vectoring mode for the tilt and
// then in rotation mode for its cosine.
// ----------------------------------------------------------------------------
module lrps_cordic
   import lrps_pkg::*;
(
   input  logic                 clock,
   input  logic                 load,
   input  logic [1:0]           phase,
   input  logic [4:0]           step,
   input  logic signed [CW-1:0] load_x,
   input  logic signed [CW-1:0] load_y,
   input  logic signed [CW-1:0] load_z,
   output logic signed [CW-1:0] x_out,
   output logic signed [CW-1:0] y_out,
   output logic signed [CW-1:0] z_out
);
   logic signed [CW-1:0] x_ff, y_ff, z_ff, x_in, y_in, z_in;
   logic signed [CW-1:0] xs, ys, ang;
   logic                 pos;

   // One micro-rotation; the direction depends on the mode.
   always_comb begin
      xs  = x_ff >>> step;
      ys  = y_ff >>> step;
      ang = atan_deg(step);
      pos = (phase == PH_VEC) ? !y_ff[CW-1] : !z_ff[CW-1];
      if (load) begin
         x_in = load_x; y_in = load_y; z_in = load_z;
      end else if ((phase == PH_VEC) == pos) begin
         // vectoring with y >= 0 or rotation with t < 0
         x_in = x_ff + ys; y_in = y_ff - xs;
         z_in = (phase == PH_VEC) ? z_ff + ang : z_ff + ang;
      end else begin
         x_in = x_ff - ys; y_in = y_ff + xs;
         z_in = z_ff - ang;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
endmodule

>>> src/laser_range_pose_solver_top.sv
// ----------------------------------------------------------------------------
// Laser range pose solver top level
// Offset, hold, CORDIC tilt and cosine, scaling and heading output.
// ----------------------------------------------------------------------------
// A transaction passes from acceptance to the result being offered through a
// hold state, a vectoring load, NSTEP vectoring steps for the tilt, a rotation
// load, NSTEP rotation steps for its cosine, a multiply state and a rounding
// state, where NSTEP is CORDIC_ITERATIONS capped at 24. The single CORDIC step
// unit runs both passes, which take most of the time. req_stall is high from
// acceptance until the result has been taken, so the next transaction can be
// accepted in the cycle after the result handshake.
module laser_range_pose_solver_top
   import lrps_pkg::*;
#(
   parameter int CORDIC_ITERATIONS = 16,
   parameter int DIST_WIDTH = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [2:0]             csr_index,
   input  logic [16:0]            csr_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_front_valid,
   input  logic [DIST_WIDTH-1:0]  req_front_dist,
   input  logic                   req_side_a_valid,
   input  logic [DIST_WIDTH-1:0]  req_side_a_dist,
   input  logic                   req_side_b_valid,
   input  logic [DIST_WIDTH-1:0]  req_side_b_dist,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [21:0]     rsp_pos_x,
   output logic signed [21:0]     rsp_pos_y,
   output logic [18:0]            rsp_heading
);
   localparam int NSTEP = (CORDIC_ITERATIONS < MAX_STEPS) ? CORDIC_ITERATIONS : MAX_STEPS;
   localparam logic [4:0] LAST = 5'(NSTEP - 1);

   localparam logic [3:0] ST_IDLE = 4'd0, ST_HOLD = 4'd1, ST_VLOAD = 4'd2,
                          ST_VEC = 4'd3, ST_RLOAD = 4'd4, ST_ROT = 4'd5,
                          ST_MUL = 4'd6, ST_FIN = 4'd7, ST_OUT = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [4:0] step_ff, step_in;

   logic mount_ff;
   logic signed [16:0] fofs_ff, aofs_ff, bofs_ff;
   logic [15:0] base_ff;
   logic signed [21:0] hf_ff, ha_ff, hb_ff;
   logic signed [DIST_WIDTH:0] fd_ff, ad_ff, bd_ff;
   logic fv_ff, av_ff, bv_ff;
   logic signed [CW-1:0] ang_ff;
   logic signed [54:0] fprod_ff, sprod_ff;
   logic signed [21:0] px_ff, py_ff;
   logic [18:0] hd_ff;

   logic cload;
   logic [1:0] cphase;
   logic signed [CW-1:0] lx, ly, lz, cx, cy, cz;
   logic signed [22:0] delta;
   logic signed [22:0] hsum;
   logic [15:0] base_eff;
   logic signed [31:0] cos_q30;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mount_ff <= 1'b0; fofs_ff <= '0; aofs_ff <= '0; bofs_ff <= '0;
         base_ff <= 16'd4096;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MOUNT_SIDE: mount_ff <= csr_data[0];
            REG_FRONT_OFS:  fofs_ff <= csr_data;
            REG_SIDE_A_OFS: aofs_ff <= csr_data;
            REG_SIDE_B_OFS: bofs_ff <= csr_data;
            REG_BASELINE:   base_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // Sequencer: hold, vectoring load and steps, rotation load and steps,
   // multiply, round, then offer the result.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_HOLD;
         ST_HOLD: state_in = ST_VLOAD;
         ST_VLOAD: begin
            state_in = ST_VEC; step_in = '0;
         end
         ST_VEC: if (step_ff == LAST) state_in = ST_RLOAD;
                 else step_in = step_ff + 5'd1;
         ST_RLOAD: begin
            state_in = ST_ROT; step_in = '0;
         end
         ST_ROT: if (step_ff == LAST) state_in = ST_MUL;
                 else step_in = step_ff + 5'd1;
         ST_MUL: state_in = ST_FIN;
         ST_FIN: state_in = ST_OUT;
         ST_OUT: if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; step_ff <= '0;
      end else begin
         state_ff <= state_in; step_ff <= step_in;
      end
   end

   // Capture the accepted transaction.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         fv_ff <= req_front_valid; av_ff <= req_side_a_valid; bv_ff <= req_side_b_valid;
         fd_ff <= $signed({1'b0, req_front_dist});
         ad_ff <= $signed({1'b0, req_side_a_dist});
         bd_ff <= $signed({1'b0, req_side_b_dist});
      end
   end

   // Held readings with offsets.
   always_ff @(posedge clock) begin
      if (reset) begin
         hf_ff <= '0; ha_ff <= '0; hb_ff <= '0;
      end else if (state_ff == ST_HOLD) begin
         if (fv_ff) hf_ff <= sat22(64'(fd_ff) + 64'(fofs_ff));
         if (av_ff) ha_ff <= sat22(64'(ad_ff) + 64'(aofs_ff));
         if (bv_ff) hb_ff <= sat22(64'(bd_ff) + 64'(bofs_ff));
      end
   end

   // CORDIC loads: the vectoring start uses the new held values, the rotation
   // start takes the angle left by vectoring.
   always_comb begin
      delta = 23'(ha_ff) - 23'(hb_ff);
      if (delta < 0) delta = -delta;
      hsum     = 23'(ha_ff) + 23'(hb_ff);
      base_eff = (base_ff == '0) ? 16'd1 : base_ff;
      cphase   = (state_ff == ST_ROT) ? PH_ROT : PH_VEC;
      cload    = (state_ff == ST_VLOAD) || (state_ff == ST_RLOAD);
      if (state_ff == ST_VLOAD) begin
         lx = CW'($signed({1'b0, base_eff, 16'd0}));
         ly = CW'($signed({delta, 16'd0}));
         lz = '0;
      end else begin
         lx = INV_GAIN_Q30;
         ly = '0;
         lz = cz;
      end
   end

   lrps_cordic u_cordic (
      .clock  (clock),
      .load   (cload),
      .phase  (cphase),
      .step   (step_ff),
      .load_x (lx),
      .load_y (ly),
      .load_z (lz),
      .x_out  (cx),
      .y_out  (cy),
      .z_out  (cz)
   );

   // The tilt is complete when the rotation pass is loaded.
   always_ff @(posedge clock) begin
      if (state_ff == ST_RLOAD) ang_ff <= cz;
   end

   // The cosine in Q30 fits in 32 bits.
   assign cos_q30 = cx[31:0];

   // Products with the rounding constant.
   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         fprod_ff <= 55'(hf_ff) * 55'(cos_q30) + (55'sd1 <<< 29);
         sprod_ff <= 55'(hsum) * 55'(cos_q30) + (55'sd1 <<< 30);
      end
   end

   logic signed [21:0] fterm, sterm;
   logic signed [CW-1:0] traw;
   logic [18:0] tdeg, hdg;
   always_comb begin
      fterm = sat22(64'(fprod_ff >>> 30));
      sterm = sat22(64'(sprod_ff >>> 31));
      traw  = (ang_ff + CW'(128)) >>> 8;
      tdeg  = traw[CW-1] ? '0 : traw[18:0];
      hdg   = (ha_ff > hb_ff) ? FULL_TURN - tdeg : tdeg;
      if (hdg >= FULL_TURN) hdg = '0;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FIN) begin
         px_ff <= mount_ff ? sterm : fterm;
         py_ff <= mount_ff ? fterm : sterm;
         hd_ff <= hdg;
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = (state_ff == ST_OUT);
   assign rsp_pos_x   = px_ff;
   assign rsp_pos_y   = py_ff;
   assign rsp_heading = hd_ff;

   logic unused_ok;
   assign unused_ok = ^{cy, cx[CW-1:32]};
endmodule

>>> src/lrps_checker.sv
// ----------------------------------------------------------------------------
// Laser range pose solver port checker
// Checks the handshake and result range as seen at the top-level ports.
// ----------------------------------------------------------------------------
module lrps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [21:0] rsp_pos_x,
   input logic [18:0] rsp_heading
);
   // A stalled result stays valid and holds its x position.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pos_x))
      else $error("result changed under stall");

   // The block takes no new transaction while a result is offered.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while result pending");

   // Heading stays below a full turn.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_heading < 19'd368640)
      else $error("heading out of range");

   // A transaction accepted leaves the input stalled next cycle.
   a_acc: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after acceptance");
endmodule

bind laser_range_pose_solver_top lrps_checker u_lrps_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_pos_x(rsp_pos_x),
   .rsp_heading(rsp_heading)
);

>>> tb/tb_laser_range_pose_solver_top.sv
// ----------------------------------------------------------------------------
// Laser range pose solver testbench
// Drives distance readings and register settings into the solver, predicts
// each pose with a CORDIC model of its own and compares every result field.
// ----------------------------------------------------------------------------
module tb_laser_range_pose_solver_top
   import lrps_pkg::*;
();

   localparam int STEPS = 16;
   localparam int DW = 20;

   typedef struct packed {
      logic signed [21:0] pos_x;
      logic signed [21:0] pos_y;
      logic [18:0]        heading;
   } pose_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = REG_MOUNT_SIDE;
   logic [16:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_front_valid = 1'b0;
   logic [DW-1:0] req_front_dist = '0;
   logic req_side_a_valid = 1'b0;
   logic [DW-1:0] req_side_a_dist = '0;
   logic req_side_b_valid = 1'b0;
   logic [DW-1:0] req_side_b_dist = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [21:0] rsp_pos_x;
   logic signed [21:0] rsp_pos_y;
   logic [18:0] rsp_heading;

   // Predictor state and configuration.
   longint hold_front, hold_a, hold_b;
   bit     cfg_right;
   longint ofs_front, ofs_a, ofs_b;
   longint cfg_base;

   pose_type pose_queue[$];
   int     mismatches = 0;
   bit     hold_rsp = 1'b0;

   laser_range_pose_solver_top i_dut (.*);

   always #1 clock = ~clock;

   // Angle of one step in 1/262144 degree.
   function automatic longint step_angle(int i);
      longint tab[24] = '{11796480, 6963869, 3679517, 1867780, 937515, 469214,
         234664, 117339, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458,
         229, 115, 57, 29, 14, 7, 4, 2};
      return tab[i];
   endfunction

   function automatic longint clip22(longint v);
      if (v < -2097152) return -2097152;
      if (v > 2097151) return 2097151;
      return v;
   endfunction

   // Apply one transaction to the held readings and work out the pose.
   function automatic pose_type solve_pose(bit fv, longint fd, bit av, longint ad,
                                           bit bv, longint bd);
      longint base, delta, vx, vy, z, cx, cy, nx, t, hd, fterm, sterm;
      pose_type p;
      if (fv) hold_front = clip22(fd + ofs_front);
      if (av) hold_a = clip22(ad + ofs_a);
      if (bv) hold_b = clip22(bd + ofs_b);
      base = (cfg_base == 0) ? 1 : cfg_base;
      delta = hold_a - hold_b;
      if (delta < 0) delta = -delta;
      vx = base * 65536;
      vy = delta * 65536;
      z = 0;
      for (int i = 0; i < STEPS; i++) begin
         if (vy >= 0) begin
            nx = vx + (vy >>> i); vy = vy - (vx >>> i); z += step_angle(i);
         end else begin
            nx = vx - (vy >>> i); vy = vy + (vx >>> i); z -= step_angle(i);
         end
         vx = nx;
      end
      cx = 652032875;
      cy = 0;
      t = z;
      for (int i = 0; i < STEPS; i++) begin
         if (t >= 0) begin
            nx = cx - (cy >>> i); cy = cy + (cx >>> i); t -= step_angle(i);
         end else begin
            nx = cx + (cy >>> i); cy = cy - (cx >>> i); t += step_angle(i);
         end
         cx = nx;
      end
      fterm = clip22((hold_front * cx + (64'sd1 <<< 29)) >>> 30);
      sterm = clip22(((hold_a + hold_b) * cx + (64'sd1 <<< 30)) >>> 31);
      t = (z + 128) >>> 8;
      if (t < 0) t = 0;
      hd = (hold_a > hold_b) ? 368640 - t : t;
      if (hd >= 368640) hd = 0;
      p.pos_x = cfg_right ? sterm[21:0] : fterm[21:0];
      p.pos_y = cfg_right ? fterm[21:0] : sterm[21:0];
      p.heading = hd[18:0];
      return p;
   endfunction

   // Register write, only while the solver is idle.
   task automatic write_reg(logic [2:0] idx, logic [16:0] value);
      @(posedge clock);
      csr_write <= 1'b1; csr_index <= idx; csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         REG_MOUNT_SIDE: cfg_right = value[0];
         REG_FRONT_OFS:  ofs_front = longint'(signed'(value));
         REG_SIDE_A_OFS: ofs_a = longint'(signed'(value));
         REG_SIDE_B_OFS: ofs_b = longint'(signed'(value));
         REG_BASELINE:   cfg_base = value[15:0];
         default: ;
      endcase
   endtask

   // Stop offering and wait until every expected result has come.
   task automatic drain();
      req_valid <= 1'b0;
      while (pose_queue.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   // Send one transaction after the given gap. The offer stays up after
   // acceptance until the next call either replaces it or drops it.
   task automatic send_reading(bit fv, logic [DW-1:0] fd, bit av, logic [DW-1:0] ad,
                               bit bv, logic [DW-1:0] bd, int gap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_front_valid <= fv; req_front_dist <= fd;
      req_side_a_valid <= av; req_side_a_dist <= ad;
      req_side_b_valid <= bv; req_side_b_dist <= bd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pose_queue.push_back(solve_pose(fv, fd, av, ad, bv, bd));
   endtask

   function automatic logic [DW-1:0] rand_dist();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return DW'($urandom_range(0, 64));
         default: return DW'($urandom);
      endcase
   endfunction

   task automatic send_random(int gap);
      send_reading($urandom_range(0, 3) != 0, rand_dist(),
                   $urandom_range(0, 3) != 0, rand_dist(),
                   $urandom_range(0, 3) != 0, rand_dist(), gap);
   endtask

   // Extremes, missing readings, overflow, mirrored and zero tilt.
   task automatic test_directed();
      send_reading(1'b1, '0, 1'b1, '0, 1'b1, '0, 0);
      send_reading(1'b1, '1, 1'b1, '1, 1'b1, '1, 0);
      send_reading(1'b1, 20'd1000, 1'b1, 20'd5000, 1'b1, 20'd1000, 0);
      send_reading(1'b1, 20'd1000, 1'b1, 20'd1000, 1'b1, 20'd5000, 0);
      send_reading(1'b0, '1, 1'b0, '0, 1'b1, 20'd5000, 0);
      send_reading(1'b0, '0, 1'b1, '1, 1'b0, '1, 0);
      send_reading(1'b1, 20'hAAAAA, 1'b1, 20'h55555, 1'b1, 20'hAAAAA, 0);
      drain();
      write_reg(REG_FRONT_OFS, 17'h0FFFF);
      write_reg(REG_SIDE_A_OFS, 17'h10000);
      write_reg(REG_SIDE_B_OFS, 17'h0FFFF);
      write_reg(REG_BASELINE, 17'h10000);   // upper bit dropped: zero baseline
      send_reading(1'b1, '1, 1'b1, '0, 1'b1, '1, 0);
      send_reading(1'b1, '0, 1'b1, '1, 1'b1, '0, 0);
      send_reading(1'b1, 20'd5, 1'b1, 20'd7, 1'b1, 20'd7, 0);
      drain();
      write_reg(REG_MOUNT_SIDE, 17'h1FFFF);
      write_reg(REG_BASELINE, 17'h0FFFF);
      send_reading(1'b1, 20'd12345, 1'b1, '1, 1'b1, '0, 0);
      send_reading(1'b1, 20'd12345, 1'b1, '0, 1'b1, '1, 0);
      drain();
   endtask

   // Random phases under several settings.
   task automatic test_random();
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(REG_MOUNT_SIDE, 17'($urandom_range(0, 1)));
         write_reg(REG_FRONT_OFS, (ph == 0) ? 17'h10000 : 17'($urandom));
         write_reg(REG_SIDE_A_OFS, (ph == 1) ? 17'h0FFFF : 17'($urandom));
         write_reg(REG_SIDE_B_OFS, 17'($urandom));
         write_reg(REG_BASELINE, (ph == 2) ? 17'd1 : 17'($urandom_range(1, 65535)));
         for (int n = 0; n < 185; n++)
            send_random((n % 40 < 10) ? 0 : $urandom_range(0, 19));
         drain();
      end
   endtask

   // Long receiver hold-off while the sender keeps offering.
   task automatic test_backpressure();
      hold_rsp <= 1'b1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         for (int n = 0; n < 12; n++) send_random(0);
      join
      drain();
   endtask

   // Receiver stall pattern: each result waits a drawn number of cycles.
   initial begin
      int wait_n;
      wait_n = $urandom_range(0, 19);
      forever begin
         @(posedge clock);
         if (hold_rsp) rsp_stall <= 1'b1;
         else begin
            if (rsp_valid && !rsp_stall) wait_n = $urandom_range(0, 19);
            else if (rsp_valid && wait_n > 0) wait_n--;
            rsp_stall <= (wait_n != 0);
         end
      end
   end

   // Result checker.
   always @(posedge clock) begin
      pose_type exp_p;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pose_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transaction");
         end else begin
            exp_p = pose_queue.pop_front();
            if (exp_p.pos_x !== rsp_pos_x || exp_p.pos_y !== rsp_pos_y ||
                exp_p.heading !== rsp_heading) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("pose mismatch: expected x=%0d y=%0d h=%0d, got x=%0d y=%0d h=%0d",
                           exp_p.pos_x, exp_p.pos_y, exp_p.heading,
                           rsp_pos_x, rsp_pos_y, rsp_heading);
            end
         end
      end
   end

   initial begin
      hold_front = 0; hold_a = 0; hold_b = 0;
      cfg_right = 0; ofs_front = 0; ofs_a = 0; ofs_b = 0; cfg_base = 4096;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random();
      test_backpressure();
      drain();
      if (mismatches == 0 && pose_queue.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   // Watchdog.
   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

endmodule

>>> files.f
src/lrps_pkg.sv
src/lrps_cordic.sv
src/laser_range_pose_solver_top.sv
src/lrps_checker.sv
tb/tb_laser_range_pose_solver_top.sv
